// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the nearest tile search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define NTKS_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define NTKS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define NTKS_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define NTKS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ===== rtl/core/ntks_pkg.sv =====
// Shared types and constants for the nearest tile of kind search.
package ntks_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int IDX_W       = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int DEPTH       = 1 << ADDR_W;

  localparam int CFG_W       = 7;
  localparam int SIZE_W      = 16;
  localparam int KIND_W      = 2;
  localparam int Q_W         = 24;
  localparam int COORD_W     = 22;
  localparam int DIFF_W      = 24;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int DIST_W      = SQ_W + 1;
  localparam int PROD_W      = IDX_W + SIZE_W;

  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE = 2'd2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Candidate tile handed to the distance pipeline.
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } dist_in_t;

  // Finished candidate plus pipeline occupancy.
  typedef struct packed {
    logic               valid;
    logic               pending;
    logic [DIST_W-1:0]  sq_dist;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } dist_out_t;

endpackage

// ===== rtl/core/nearest_tile_of_kind_search.sv =====
// Top level of the nearest tile of kind search: tile memory, scan control, best tracking.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  request   | start / busy              | command, tile_column, tile_row, kind,
//            |                           | query_x, query_y
//  result    | result_valid (one cycle)  | found, nearest_x, nearest_y
//  config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  A write request leaves busy low, so writes can stream back to back.
//  A query keeps busy high while the clamped map is scanned, one tile per cycle through the
//  single read port of the tile memory, and while the distance pipeline drains; the drain is
//  shorter when the last tiles do not match, and an empty map skips the scan.
//  After reset the tile memory is cleared one entry per cycle with busy high;
//  config writes are taken during that pass.
//  result_valid pulses once per query and cannot be stalled by the receiver.
`include "assert_macros.svh"

module nearest_tile_of_kind_search (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  command,
  input  logic [5:0]                            tile_column,
  input  logic [5:0]                            tile_row,
  input  logic [ntks_pkg::KIND_W-1:0]           kind,
  input  logic signed [ntks_pkg::Q_W-1:0]       query_x,
  input  logic signed [ntks_pkg::Q_W-1:0]       query_y,
  output logic                                  result_valid,
  output logic                                  found,
  output logic [ntks_pkg::COORD_W-1:0]          nearest_x,
  output logic [ntks_pkg::COORD_W-1:0]          nearest_y,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ntks_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ntks_pkg::SIZE_W-1:0]           cfg_data
);
  import ntks_pkg::*;

  // Corner coordinate of a tile index, saturated to the coordinate range.
  function automatic logic [COORD_W-1:0] corner(input logic [IDX_W-1:0] idx,
                                                input logic [SIZE_W-1:0] size);
    logic [PROD_W-1:0] p;
    p = PROD_W'(idx) * PROD_W'(size);
    if (p > PROD_W'(COORD_MAX)) begin
      return COORD_MAX;
    end
    return COORD_W'(p);
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0]  columns_in_use;
  logic [CFG_W-1:0]  rows_in_use;
  logic [SIZE_W-1:0] tile_size;

  // Control.
  state_t             state;
  state_t             state_next;
  logic [ADDR_W-1:0]  clear_addr;
  logic [COL_W-1:0]   scan_col;
  logic [ROW_W-1:0]   scan_row;
  logic [CFG_W-1:0]   ncols;
  logic [CFG_W-1:0]   nrows;
  logic               accept;
  logic               query_go;
  logic               issue;
  logic               last_tile;
  logic               empty_map;

  // Held query.
  logic signed [Q_W-1:0] qx;
  logic signed [Q_W-1:0] qy;
  logic [KIND_W-1:0]     qkind;

  // Tile memory.
  logic [KIND_W-1:0] tile_mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [KIND_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [KIND_W-1:0] rd_data;

  // Read stage, aligned with rd_data.
  logic               s1_valid;
  logic [COORD_W-1:0] s1_cx;
  logic [COORD_W-1:0] s1_cy;

  dist_in_t  pipe_in;
  dist_out_t pipe_out;

  // Running best.
  logic               match_seen;
  logic [DIST_W-1:0]  best_dist;
  logic [COORD_W-1:0] best_x;
  logic [COORD_W-1:0] best_y;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign query_go  = accept && (command == CMD_QUERY);

  // Clamp map size to the memory grid.
  assign ncols = (columns_in_use > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : columns_in_use;
  assign nrows = (rows_in_use > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_in_use;
  assign empty_map = (ncols == '0) || (nrows == '0);

  assign last_tile = (CFG_W'(scan_col) == ncols - CFG_W'(1)) &&
                     (CFG_W'(scan_row) == nrows - CFG_W'(1));

  // Config writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= CFG_W'(64);
      rows_in_use    <= CFG_W'(64);
      tile_size      <= SIZE_W'(8192);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COLUMNS:   columns_in_use <= cfg_data[CFG_W-1:0];
        CFG_ROWS:      rows_in_use    <= cfg_data[CFG_W-1:0];
        CFG_TILE_SIZE: tile_size      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clear_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (query_go) begin
          state_next = empty_map ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_tile) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !pipe_out.pending) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    busy         = 1'b1;
    result_valid = 1'b0;
    issue        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = clear_addr;
    mem_wdata    = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        busy      = 1'b0;
        mem_waddr = {tile_row[ROW_W-1:0], tile_column[COL_W-1:0]};
        mem_wdata = kind;
        // Drop writes outside the grid.
        mem_we    = accept && (command == CMD_WRITE) &&
                    (int'(tile_column) < MAX_COLUMNS) && (int'(tile_row) < MAX_ROWS);
      end
      ST_SCAN:  issue = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  result_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      scan_col   <= '0;
      scan_row   <= '0;
      s1_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= issue;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + ADDR_W'(1);
      end
      // Advance the row-major scan position.
      if (query_go) begin
        scan_col <= '0;
        scan_row <= '0;
      end else if (issue) begin
        if (CFG_W'(scan_col) == ncols - CFG_W'(1)) begin
          scan_col <= '0;
          scan_row <= scan_row + ROW_W'(1);
        end else begin
          scan_col <= scan_col + COL_W'(1);
        end
      end
    end
  end

  // Hold the query fields for the whole scan.
  always_ff @(posedge clk) begin
    if (query_go) begin
      qx    <= query_x;
      qy    <= query_y;
      qkind <= kind;
    end
  end

  // Tile memory: one write port, one registered read port.
  assign rd_addr = {scan_row, scan_col};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tile_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= tile_mem[rd_addr];
  end

  // Corners travel alongside the memory read.
  always_ff @(posedge clk) begin
    s1_cx <= corner(IDX_W'(scan_col), tile_size);
    s1_cy <= corner(IDX_W'(scan_row), tile_size);
  end

  // Only tiles of the wanted kind enter the distance pipeline.
  always_comb begin
    pipe_in.valid = s1_valid && (rd_data == qkind);
    pipe_in.cx    = s1_cx;
    pipe_in.cy    = s1_cy;
  end

  ntks_dist_pipe u_dist (
    .clk  (clk),
    .rst  (rst),
    .din  (pipe_in),
    .qx   (qx),
    .qy   (qy),
    .dout (pipe_out)
  );

  // Keep the first strictly nearer match; ties keep the earlier tile.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_seen <= 1'b0;
      best_dist  <= '1;
      best_x     <= '0;
      best_y     <= '0;
    end else if (query_go) begin
      match_seen <= 1'b0;
      best_dist  <= '1;
      best_x     <= '0;
      best_y     <= '0;
    end else if (pipe_out.valid && (!match_seen || (pipe_out.sq_dist < best_dist))) begin
      match_seen <= 1'b1;
      best_dist  <= pipe_out.sq_dist;
      best_x     <= pipe_out.cx;
      best_y     <= pipe_out.cy;
    end
  end

  assign found     = match_seen;
  assign nearest_x = best_x;
  assign nearest_y = best_y;

  `NTKS_ASSERT_NEXT(a_strobe_single, clk, rst, result_valid, !result_valid)
  `NTKS_ASSERT_IMPL(a_miss_zero, clk, rst, result_valid && !found, nearest_x == '0 && nearest_y == '0)
  `NTKS_ASSERT_NEXT(a_query_busy, clk, rst, start && !busy && command == CMD_QUERY, busy)
  `NTKS_ASSERT_IMPL(a_write_idle, clk, rst, mem_we && state != ST_CLEAR, state == ST_IDLE)

endmodule

// ===== rtl/core/ntks_dist_pipe.sv =====
// Three-stage squared distance pipeline: absolute difference, square, sum.
module ntks_dist_pipe (
  input  logic                              clk,
  input  logic                              rst,
  input  ntks_pkg::dist_in_t                din,
  input  logic signed [ntks_pkg::Q_W-1:0]   qx,
  input  logic signed [ntks_pkg::Q_W-1:0]   qy,
  output ntks_pkg::dist_out_t               dout
);
  import ntks_pkg::*;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] c,
                                                 input logic signed [Q_W-1:0] q);
    logic [Q_W:0] d;
    d = {{(Q_W + 1 - COORD_W){1'b0}}, c} - {q[Q_W-1], q};
    if (d[Q_W]) begin
      return DIFF_W'(-d);
    end
    return DIFF_W'(d);
  endfunction

  logic               a_valid;
  logic [DIFF_W-1:0]  a_dx;
  logic [DIFF_W-1:0]  a_dy;
  logic [COORD_W-1:0] a_cx;
  logic [COORD_W-1:0] a_cy;

  logic               b_valid;
  logic [SQ_W-1:0]    b_dx2;
  logic [SQ_W-1:0]    b_dy2;
  logic [COORD_W-1:0] b_cx;
  logic [COORD_W-1:0] b_cy;

  logic               c_valid;
  logic [DIST_W-1:0]  c_dist;
  logic [COORD_W-1:0] c_cx;
  logic [COORD_W-1:0] c_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= din.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_dx   <= abs_diff(din.cx, qx);
    a_dy   <= abs_diff(din.cy, qy);
    a_cx   <= din.cx;
    a_cy   <= din.cy;
    b_dx2  <= SQ_W'(a_dx) * SQ_W'(a_dx);
    b_dy2  <= SQ_W'(a_dy) * SQ_W'(a_dy);
    b_cx   <= a_cx;
    b_cy   <= a_cy;
    c_dist <= DIST_W'(b_dx2) + DIST_W'(b_dy2);
    c_cx   <= b_cx;
    c_cy   <= b_cy;
  end

  always_comb begin
    dout.valid   = c_valid;
    dout.pending = a_valid | b_valid | c_valid;
    dout.sq_dist = c_dist;
    dout.cx      = c_cx;
    dout.cy      = c_cy;
  end

endmodule

// ===== tb/nearest_tile_of_kind_search_tb.sv =====
// Self-checking testbench for the nearest tile of kind search: directed corners, then random maps and a steady stream.
module nearest_tile_of_kind_search_tb;
  import ntks_pkg::*;

  // Tile kinds as the block stores them; the fourth code is stored and searched as is.
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STONE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  // Register index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [Q_W-1:0] Q_MOST  = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_LEAST = {1'b1, {(Q_W-1){1'b0}}};

  // Worst correct run is the clearing pass plus six full-map
  // queries; the limit leaves a wide margin over that.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // Wait after the block is free before touching a register.
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } tile_hit_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   command;
  logic [5:0]             tile_column;
  logic [5:0]             tile_row;
  logic [KIND_W-1:0]      kind;
  logic signed [Q_W-1:0]  query_x;
  logic signed [Q_W-1:0]  query_y;
  logic                   result_valid;
  logic                   found;
  logic [COORD_W-1:0]     nearest_x;
  logic [COORD_W-1:0]     nearest_y;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [SIZE_W-1:0]      cfg_data;

  // Shadow of the block: tile kinds and the three registers.
  logic [KIND_W-1:0]      tile_kinds [DEPTH];
  logic [CFG_W-1:0]       map_cols;
  logic [CFG_W-1:0]       map_rows;
  logic [SIZE_W-1:0]      tile_size_q;

  // Query answers still owed by the block, oldest first.
  tile_hit_t              pending_results [$];

  int unsigned            failures    = 0;
  int unsigned            cycle_count = 0;
  // Set to hold the sender on every cycle, for a stretch with no gaps.
  bit                     steady      = 1'b0;

  nearest_tile_of_kind_search u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .tile_column  (tile_column),
    .tile_row     (tile_row),
    .kind         (kind),
    .query_x      (query_x),
    .query_y      (query_y),
    .result_valid (result_valid),
    .found        (found),
    .nearest_x    (nearest_x),
    .nearest_y    (nearest_y),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Corner coordinate of a tile index, saturated to the 22-bit output range.
  function automatic logic [COORD_W-1:0] tile_corner(int unsigned index);
    longint unsigned pos;
    pos = longint'(index) * longint'(tile_size_q);
    if (pos > longint'(COORD_MAX))
      pos = longint'(COORD_MAX);
    return pos[COORD_W-1:0];
  endfunction

  function automatic longint unsigned squared_gap(logic [COORD_W-1:0] c,
                                                  logic signed [Q_W-1:0] q);
    longint d;
    d = longint'(c) - longint'(q);
    return d * d;
  endfunction

  // Scan the shadow grid in row-major order; a strict less-than keeps the first of a tie.
  function automatic tile_hit_t nearest_match(logic [KIND_W-1:0] want,
                                              logic signed [Q_W-1:0] qx,
                                              logic signed [Q_W-1:0] qy);
    tile_hit_t          hit;
    longint unsigned    best;
    longint unsigned    gap2;
    longint unsigned    dy2;
    int unsigned        ncols;
    int unsigned        nrows;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    hit   = '0;
    best  = '1;
    ncols = (map_cols > MAX_COLUMNS) ? MAX_COLUMNS : map_cols;
    nrows = (map_rows > MAX_ROWS) ? MAX_ROWS : map_rows;
    for (int unsigned r = 0; r < nrows; r++) begin
      cy  = tile_corner(r);
      dy2 = squared_gap(cy, qy);
      for (int unsigned c = 0; c < ncols; c++) begin
        if (tile_kinds[r * MAX_COLUMNS + c] == want) begin
          cx   = tile_corner(c);
          gap2 = squared_gap(cx, qx) + dy2;
          if (!hit.found || gap2 < best) begin
            best      = gap2;
            hit.found = 1'b1;
            hit.x     = cx;
            hit.y     = cy;
          end
        end
      end
    end
    return hit;
  endfunction

  // Compare every result with the oldest owed answer.
  always @(posedge clk) begin : check_results
    tile_hit_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no query pending");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          failures++;
        end
        if (nearest_x !== want.x) begin
          $error("nearest_x: expected %0d, got %0d", want.x, nearest_x);
          failures++;
        end
        if (nearest_y !== want.y) begin
          $error("nearest_y: expected %0d, got %0d", want.y, nearest_y);
          failures++;
        end
      end
    end
  end

  // Idle with a chance of about one in five unless the steady stretch is on.
  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < 21);
  endfunction

  // Drop both valids, then hold until no answer is owed and the block is free.
  task automatic wait_idle();
    @(negedge clk);
    start     <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register once the block is idle; mirror it into the shadow on acceptance.
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    wait_idle();
    while (take_gap()) begin
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COLUMNS:   map_cols    = data[CFG_W-1:0];
      CFG_ROWS:      map_rows    = data[CFG_W-1:0];
      CFG_TILE_SIZE: tile_size_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Present one request, hold it until the block takes it, then update the shadow.
  task automatic send_request(input cmd_t cmd, input logic [5:0] col, input logic [5:0] row,
                              input logic [KIND_W-1:0] k, input logic signed [Q_W-1:0] qx,
                              input logic signed [Q_W-1:0] qy);
    while (take_gap()) begin
      @(negedge clk);
      start     <= 1'b0;
      cfg_valid <= 1'b0;
    end
    @(negedge clk);
    cfg_valid   <= 1'b0;
    start       <= 1'b1;
    command     <= cmd;
    tile_column <= col;
    tile_row    <= row;
    kind        <= k;
    query_x     <= qx;
    query_y     <= qy;
    do @(posedge clk); while (busy);
    if (cmd == CMD_QUERY)
      pending_results.push_back(nearest_match(k, qx, qy));
    else if (col < MAX_COLUMNS && row < MAX_ROWS)
      tile_kinds[row * MAX_COLUMNS + col] = k;
  endtask

  // Unused fields carry random junk so that every port bit toggles.
  task automatic write_tile(input int unsigned col, input int unsigned row,
                            input logic [KIND_W-1:0] k);
    send_request(CMD_WRITE, col[5:0], row[5:0], k, Q_W'($urandom()), Q_W'($urandom()));
  endtask

  task automatic query_nearest(input logic [KIND_W-1:0] k, input logic signed [Q_W-1:0] qx,
                               input logic signed [Q_W-1:0] qy);
    send_request(CMD_QUERY, 6'($urandom()), 6'($urandom()), k, qx, qy);
  endtask

  // Query coordinate along an axis of span tiles: on or beside a corner, somewhere
  // across the map, or anywhere in the signed range.
  function automatic logic signed [Q_W-1:0] pick_coord(int unsigned span);
    longint      v;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4)
      v = longint'($urandom_range(0, span)) * longint'(tile_size_q)
          + longint'($urandom_range(0, 4)) - 2;
    else if (sel < 7)
      v = longint'($urandom_range(0, (span + 1) * tile_size_q)) - longint'(tile_size_q);
    else
      v = longint'($urandom());
    return v[Q_W-1:0];
  endfunction

  // One random request: mostly writes inside the scanned area, the rest queries.
  task automatic random_request();
    int unsigned ecols;
    int unsigned erows;
    int unsigned col;
    int unsigned row;
    ecols = (map_cols > MAX_COLUMNS) ? MAX_COLUMNS : map_cols;
    erows = (map_rows > MAX_ROWS) ? MAX_ROWS : map_rows;
    if ($urandom_range(0, 99) < 55) begin
      col = (ecols > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, ecols - 1)
                                                      : $urandom_range(0, 63);
      row = (erows > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, erows - 1)
                                                      : $urandom_range(0, 63);
      write_tile(col, row, KIND_W'($urandom_range(0, 3)));
    end else begin
      query_nearest(KIND_W'($urandom_range(0, 3)), pick_coord(ecols), pick_coord(erows));
    end
  endtask

  // Reset values: the first query also waits out the clearing pass.
  task automatic test_reset_state();
    query_nearest(KIND_EMPTY, Q_LEAST, Q_LEAST);
    query_nearest(KIND_TREE, Q_MOST, Q_MOST);
  endtask

  // Every kind, far grid corners and the extremes of the query point, on the full map.
  task automatic test_kind_extremes();
    write_tile(63, 63, KIND_TREE);
    write_tile(0, 63, KIND_STONE);
    write_tile(63, 0, KIND_SPARE);
    write_tile(5, 7, KIND_TREE);
    query_nearest(KIND_TREE, Q_MOST, Q_MOST);
    query_nearest(KIND_STONE, Q_LEAST, Q_MOST);
    query_nearest(KIND_SPARE, 24'sd0, 24'sd0);
    // The nearest empty tile to the far corner sits on a tie; scan order decides it.
    query_nearest(KIND_EMPTY, 24'sd516096, 24'sd516096);
  endtask

  // Zero sizes scan nothing, oversized sizes clamp, upper data bits and the spare index drop.
  task automatic test_map_size_edges();
    set_register(CFG_COLUMNS, 16'h0000);
    query_nearest(KIND_EMPTY, 24'sd0, 24'sd0);
    set_register(CFG_COLUMNS, 16'hFF7F);
    set_register(CFG_ROWS, 16'h0000);
    query_nearest(KIND_EMPTY, 24'sd0, 24'sd0);
    set_register(CFG_ROWS, 16'hAB01);
    write_tile(10, 0, KIND_STONE);
    query_nearest(KIND_STONE, Q_MOST, Q_LEAST);
    set_register(CFG_COLUMNS, 16'h0001);
    set_register(CFG_ROWS, 16'h0040);
    write_tile(0, 40, KIND_TREE);
    query_nearest(KIND_TREE, 24'sd0, Q_MOST);
    set_register(CFG_UNUSED, SIZE_W'($urandom()));
    query_nearest(KIND_EMPTY, 24'sd0, 24'sd0);
  endtask

  // Tile size at one, zero and full scale, plus an exact distance tie.
  task automatic test_tile_size_edges();
    set_register(CFG_COLUMNS, 16'd64);
    set_register(CFG_ROWS, 16'd4);
    write_tile(0, 0, KIND_TREE);
    write_tile(1, 0, KIND_STONE);
    write_tile(0, 1, KIND_STONE);
    set_register(CFG_TILE_SIZE, 16'd256);
    query_nearest(KIND_STONE, 24'sd0, 24'sd0);
    // Every corner collapses onto the origin; the first stone in scan order wins.
    set_register(CFG_TILE_SIZE, 16'd0);
    query_nearest(KIND_STONE, Q_MOST, Q_LEAST);
    set_register(CFG_TILE_SIZE, 16'hFFFF);
    query_nearest(KIND_STONE, Q_MOST, Q_MOST);
    query_nearest(KIND_SPARE, Q_MOST, Q_LEAST);
    set_register(CFG_TILE_SIZE, 16'd1);
    query_nearest(KIND_EMPTY, 24'sd3, 24'sd3);
  endtask

  // Random map shapes, mostly small so each query scans only a few dozen tiles.
  task automatic test_random_maps();
    int unsigned      cols;
    int unsigned      rows;
    logic [SIZE_W-1:0] d;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 9))
        0: begin
          cols = 64;
          rows = $urandom_range(1, 2);
        end
        1: begin
          cols = $urandom_range(1, 2);
          rows = 64;
        end
        2: begin
          cols = $urandom_range(65, 127);
          rows = 1;
        end
        3: begin
          cols = $urandom_range(0, 1) ? 0 : 3;
          rows = $urandom_range(0, 3);
        end
        default: begin
          cols = $urandom_range(1, 8);
          rows = $urandom_range(1, 8);
        end
      endcase
      d        = SIZE_W'($urandom());
      d[6:0]   = cols[6:0];
      set_register(CFG_COLUMNS, d);
      d        = SIZE_W'($urandom());
      d[6:0]   = rows[6:0];
      set_register(CFG_ROWS, d);
      case ($urandom_range(0, 5))
        0:       d = 16'd0;
        1:       d = 16'hFFFF;
        2:       d = SIZE_W'($urandom_range(1, 512));
        default: d = SIZE_W'($urandom_range(1, 65535));
      endcase
      set_register(CFG_TILE_SIZE, d);
      repeat (16) random_request();
    end
  endtask

  // Back-to-back requests with the sender never idling.
  task automatic test_steady_stream();
    set_register(CFG_COLUMNS, 16'd4);
    set_register(CFG_ROWS, 16'd3);
    set_register(CFG_TILE_SIZE, SIZE_W'($urandom_range(1, 1024)));
    steady = 1'b1;
    repeat (20) random_request();
    steady = 1'b0;
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    rst         = 1'b1;
    start       = 1'b0;
    command     = CMD_WRITE;
    tile_column = '0;
    tile_row    = '0;
    kind        = KIND_EMPTY;
    query_x     = '0;
    query_y     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_COLUMNS;
    cfg_data    = '0;
    for (int i = 0; i < DEPTH; i++)
      tile_kinds[i] = KIND_EMPTY;
    map_cols    = 7'd64;
    map_rows    = 7'd64;
    tile_size_q = 16'd8192;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_kind_extremes();
    test_map_size_edges();
    test_tile_size_edges();
    test_random_maps();
    test_steady_stream();

    // Drain owed answers, then give the block time to show any stray result.
    wait_idle();
    if (failures == 0 && pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
